[rtl/spte_pkg.sv]
package spte_pkg;

  localparam int MAX_TERMS = 32;
  localparam int EXP_BITS  = 16;
  localparam int COEF_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_TERMS);
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int TERM_W = EXP_BITS + COEF_BITS;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EOVF = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  typedef struct packed {
    logic signed [EXP_BITS-1:0]  exp;
    logic signed [COEF_BITS-1:0] coef;
  } term_t;

  typedef struct packed {
    logic [2:0]                  op;
    logic signed [EXP_BITS-1:0]  term_exponent;
    logic signed [COEF_BITS-1:0] term_coefficient;
  } cmd_t;

  typedef struct packed {
    logic signed [EXP_BITS-1:0]  out_exponent;
    logic signed [COEF_BITS-1:0] out_coefficient;
    logic                        term_valid;
    logic                        last;
    logic [1:0]                  status;
  } res_t;

  // request to the insert walker
  typedef struct packed {
    logic  start;
    term_t t;
    cnt_t  n;
  } ins_req_t;

  // completion from the insert walker
  typedef struct packed {
    logic       done;
    logic [1:0] status;
    cnt_t       cnt;
  } ins_rsp_t;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    term_t data;
  } mem_wr_t;

endpackage

[rtl/spte_ram.sv]
module spte_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/spte_mul.sv]
module spte_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_v,
  input  logic signed [spte_pkg::COEF_BITS-1:0] a,
  input  logic signed [spte_pkg::COEF_BITS-1:0] b,
  output logic                               out_v,
  output logic signed [spte_pkg::COEF_BITS-1:0] c,
  output logic                               sat
);
  import spte_pkg::*;

  localparam int PW = 2 * COEF_BITS + 1;
  localparam logic [PW-1:0] RND = (FRAC_BITS > 0) ? (PW'(1) << (FRAC_BITS - 1)) : '0;
  localparam logic [PW-1:0] LIM_POS = (PW'(1) << (COEF_BITS - 1)) - PW'(1);
  localparam logic [PW-1:0] LIM_NEG = PW'(1) << (COEF_BITS - 1);

  logic                   v1, v2;
  logic                   neg1, neg2;
  logic [COEF_BITS-1:0]   ma, mb;
  logic [2*COEF_BITS-1:0] prod;
  logic [PW-1:0]          rounded, limit;
  logic [COEF_BITS-1:0]   mag;
  logic                   over;

  // round half away from zero, then clamp the magnitude
  always_comb begin
    rounded = ({1'b0, prod} + RND) >> FRAC_BITS;
    limit   = neg2 ? LIM_NEG : LIM_POS;
    over    = rounded > limit;
    mag     = over ? limit[COEF_BITS-1:0] : rounded[COEF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
    // magnitudes
    neg1 <= a[COEF_BITS-1] ^ b[COEF_BITS-1];
    ma   <= a[COEF_BITS-1] ? COEF_BITS'(-a) : COEF_BITS'(a);
    mb   <= b[COEF_BITS-1] ? COEF_BITS'(-b) : COEF_BITS'(b);
    // product
    neg2 <= neg1;
    prod <= ma * mb;
    // result
    c    <= neg2 ? COEF_BITS'(-mag) : COEF_BITS'(mag);
    sat  <= over;
  end

endmodule

[rtl/spte_insert.sv]
module spte_insert (
  input  logic                clk,
  input  logic                rst,
  input  spte_pkg::ins_req_t  req,
  input  spte_pkg::term_t     rdata,
  output spte_pkg::idx_t      raddr,
  output spte_pkg::mem_wr_t   wr,
  output spte_pkg::ins_rsp_t  rsp
);
  import spte_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} state_t;

  state_t state;
  cnt_t   ptr, n;
  term_t  nt, carry;
  cnt_t   ptr_p1;
  logic   full, advance, take_carry;
  logic   [1:0] state_sel;
  logic signed [COEF_BITS:0] sum;
  logic signed [COEF_BITS-1:0] sum_sat;
  logic   sum_ovf;

  assign ptr_p1 = ptr + cnt_t'(1);
  assign full   = (n == cnt_t'(MAX_TERMS));
  assign raddr  = (state == S_IDLE) ? '0 : ptr_p1[IDX_W-1:0];

  // saturating accumulate for a matching exponent
  always_comb begin
    sum     = {rdata.coef[COEF_BITS-1], rdata.coef} + {nt.coef[COEF_BITS-1], nt.coef};
    sum_ovf = sum[COEF_BITS] != sum[COEF_BITS-1];
    if (sum_ovf) begin
      sum_sat = sum[COEF_BITS] ? {1'b1, {(COEF_BITS-1){1'b0}}} : {1'b0, {(COEF_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum[COEF_BITS-1:0];
    end
  end

  // walk decisions
  always_comb begin
    wr         = '0;
    wr.addr    = ptr[IDX_W-1:0];
    rsp        = '0;
    rsp.cnt    = n;
    advance    = 1'b0;
    take_carry = 1'b0;
    state_sel  = 2'd0;
    unique case (state)
      S_IDLE: begin
      end
      S_SCAN: begin
        priority if (ptr == n) begin
          rsp.done = 1'b1;
          if (full) begin
            rsp.status = ST_FULL;
          end else begin
            wr.we   = 1'b1;
            wr.data = nt;
            rsp.cnt = n + cnt_t'(1);
          end
        end else if (rdata.exp > nt.exp) begin
          advance = 1'b1;
        end else if (rdata.exp == nt.exp) begin
          rsp.done      = 1'b1;
          wr.we         = 1'b1;
          wr.data.exp   = rdata.exp;
          wr.data.coef  = sum_sat;
          rsp.status    = sum_ovf ? ST_SAT : ST_OK;
        end else if (full) begin
          rsp.done   = 1'b1;
          rsp.status = ST_FULL;
        end else begin
          wr.we      = 1'b1;
          wr.data    = nt;
          advance    = 1'b1;
          take_carry = 1'b1;
          state_sel  = 2'd1;
        end
      end
      S_SHIFT: begin
        wr.we   = 1'b1;
        wr.data = carry;
        if (ptr == n) begin
          rsp.done = 1'b1;
          rsp.cnt  = n + cnt_t'(1);
        end else begin
          advance    = 1'b1;
          take_carry = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_SCAN;
            ptr   <= '0;
            n     <= req.n;
            nt    <= req.t;
          end
        end
        S_SCAN, S_SHIFT: begin
          if (rsp.done) begin
            state <= S_IDLE;
          end else if (state_sel == 2'd1) begin
            state <= S_SHIFT;
          end
          if (advance) begin
            ptr <= ptr_p1;
          end
          if (take_carry) begin
            carry <= rdata;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sparse_polynomial_term_engine.sv]
// Channel  Direction  Word    Handshake
// cmd      in         cmd_t   cmd_valid / cmd_ready
// res      out        res_t   res_valid / res_ready
//
// One command at a time. An insert or operand load walks the sorted table
// in the walker, then its reply is queued. Multiply sums the exponents and
// multiplies the coefficients of each pair of terms, then inserts the product
// through the walker; readout reads each term, then loads it for output.
// Reset (rst, synchronous) empties all tables by clearing their counts.
// A stalled result holds in the output register; the engine waits there.
module sparse_polynomial_term_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  spte_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output spte_pkg::res_t res
);
  import spte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_MRD, S_MEX, S_MWAIT, S_MINS, S_ORD, S_OLD, S_RESP
  } state_t;

  typedef enum logic [1:0] {T_MAIN, T_OPER, T_PROD} tgt_t;

  state_t     state;
  tgt_t       tgt, tgt_cur;
  logic       sel;
  cnt_t       bcnt [2];
  cnt_t       opcnt, aidx, j;
  logic [1:0] st;
  logic signed [EXP_BITS-1:0] esum_r;

  ins_req_t   ins_req;
  ins_rsp_t   ins_rsp;
  idx_t       w_raddr;
  mem_wr_t    w_wr;
  term_t      w_rdata;
  term_t      brdata [2];
  term_t      ordata;
  term_t      mrow;

  logic       mul_v, mul_ov, mul_sat;
  logic signed [COEF_BITS-1:0] mul_c;
  logic signed [EXP_BITS:0]    esum;
  logic       eovf, j_wrap, i_last, out_free, accept, walk_on, res_load;
  cnt_t       main_cnt, prod_cnt;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;
  assign res_load  = out_free && (state == S_OLD || state == S_RESP);
  assign main_cnt  = bcnt[sel];
  assign prod_cnt  = bcnt[~sel];
  assign mrow      = brdata[sel];

  // target of the walker, live while a command is being accepted
  always_comb begin
    tgt_cur = tgt;
    if (state == S_IDLE) begin
      tgt_cur = (cmd.op == OP_LOAD) ? T_OPER : T_MAIN;
    end
  end

  // walker request
  always_comb begin
    ins_req = '0;
    if (state == S_IDLE) begin
      ins_req.start  = accept && (cmd.op == OP_INSERT || cmd.op == OP_LOAD);
      ins_req.t.exp  = cmd.term_exponent;
      ins_req.t.coef = cmd.term_coefficient;
      ins_req.n      = (cmd.op == OP_LOAD) ? opcnt : main_cnt;
    end else begin
      ins_req.start  = (state == S_MWAIT) && mul_ov;
      ins_req.t.exp  = esum_r;
      ins_req.t.coef = mul_c;
      ins_req.n      = prod_cnt;
    end
  end

  assign walk_on = ins_req.start || state == S_INS || state == S_MINS;

  // table memories
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic own;
    assign own = walk_on && ((tgt_cur == T_MAIN && sel == 1'(b)) ||
                             (tgt_cur == T_PROD && sel != 1'(b)));
    spte_ram #(.W(TERM_W), .DEPTH(MAX_TERMS)) u_bank (
      .clk   (clk),
      .raddr (own ? w_raddr : aidx[IDX_W-1:0]),
      .we    (own && w_wr.we),
      .waddr (w_wr.addr),
      .wdata (w_wr.data),
      .rdata (brdata[b])
    );
  end

  logic oown;
  assign oown = walk_on && tgt_cur == T_OPER;

  spte_ram #(.W(TERM_W), .DEPTH(MAX_TERMS)) u_oper (
    .clk   (clk),
    .raddr (oown ? w_raddr : j[IDX_W-1:0]),
    .we    (oown && w_wr.we),
    .waddr (w_wr.addr),
    .wdata (w_wr.data),
    .rdata (ordata)
  );

  always_comb begin
    unique case (tgt_cur)
      T_OPER:  w_rdata = ordata;
      T_PROD:  w_rdata = brdata[~sel];
      default: w_rdata = brdata[sel];
    endcase
  end

  spte_insert u_ins (
    .clk   (clk),
    .rst   (rst),
    .req   (ins_req),
    .rdata (w_rdata),
    .raddr (w_raddr),
    .wr    (w_wr),
    .rsp   (ins_rsp)
  );

  assign mul_v = (state == S_MEX) && !eovf;

  spte_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .in_v  (mul_v),
    .a     (mrow.coef),
    .b     (ordata.coef),
    .out_v (mul_ov),
    .c     (mul_c),
    .sat   (mul_sat)
  );

  // exponent sum and pair stepping
  assign esum   = {mrow.exp[EXP_BITS-1], mrow.exp} + {ordata.exp[EXP_BITS-1], ordata.exp};
  assign eovf   = esum[EXP_BITS] != esum[EXP_BITS-1];
  assign j_wrap = (j + cnt_t'(1)) == opcnt;
  assign i_last = (aidx + cnt_t'(1)) == main_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tgt       <= T_MAIN;
      sel       <= 1'b0;
      bcnt[0]   <= '0;
      bcnt[1]   <= '0;
      opcnt     <= '0;
      res_valid <= 1'b0;
      st        <= ST_OK;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            st   <= ST_OK;
            aidx <= '0;
            j    <= '0;
            tgt  <= (cmd.op == OP_MUL) ? T_PROD : tgt_cur;
            unique case (cmd.op)
              OP_INSERT, OP_LOAD: state <= S_INS;
              OP_MUL: begin
                if (opcnt == '0 || main_cnt == '0) begin
                  bcnt[sel] <= '0;
                  opcnt     <= '0;
                  state     <= S_RESP;
                end else begin
                  bcnt[~sel] <= '0;
                  state      <= S_MRD;
                end
              end
              OP_CLEAR: begin
                bcnt[sel] <= '0;
                state     <= S_RESP;
              end
              OP_READ: state <= (main_cnt == '0) ? S_RESP : S_ORD;
              default: state <= S_RESP;
            endcase
          end
        end
        S_INS: begin
          if (ins_rsp.done) begin
            st <= ins_rsp.status;
            if (tgt == T_OPER) begin
              opcnt <= ins_rsp.cnt;
            end else begin
              bcnt[sel] <= ins_rsp.cnt;
            end
            state <= S_RESP;
          end
        end
        S_MRD: state <= S_MEX;
        S_MEX: begin
          esum_r <= esum[EXP_BITS-1:0];
          if (eovf) begin
            if (st == ST_OK) st <= ST_EOVF;
            // skip this pair
            if (j_wrap) begin
              j <= '0;
              if (i_last) begin
                sel   <= ~sel;
                opcnt <= '0;
                state <= S_RESP;
              end else begin
                aidx  <= aidx + cnt_t'(1);
                state <= S_MRD;
              end
            end else begin
              j     <= j + cnt_t'(1);
              state <= S_MRD;
            end
          end else begin
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (mul_ov) begin
            if (mul_sat && st == ST_OK) st <= ST_SAT;
            state <= S_MINS;
          end
        end
        S_MINS: begin
          if (ins_rsp.done) begin
            if (st == ST_OK) st <= ins_rsp.status;
            bcnt[~sel] <= ins_rsp.cnt;
            if (j_wrap) begin
              j <= '0;
              if (i_last) begin
                sel   <= ~sel;
                opcnt <= '0;
                state <= S_RESP;
              end else begin
                aidx  <= aidx + cnt_t'(1);
                state <= S_MRD;
              end
            end else begin
              j     <= j + cnt_t'(1);
              state <= S_MRD;
            end
          end
        end
        S_ORD: state <= S_OLD;
        S_OLD: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res.out_exponent    <= mrow.exp;
            res.out_coefficient <= mrow.coef;
            res.term_valid      <= 1'b1;
            res.last            <= i_last;
            res.status          <= ST_OK;
            aidx                <= aidx + cnt_t'(1);
            state               <= i_last ? S_IDLE : S_ORD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res.out_exponent    <= '0;
            res.out_coefficient <= '0;
            res.term_valid      <= 1'b0;
            res.last            <= 1'b1;
            res.status          <= st;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/spte_chk.sv]
module spte_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input spte_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_ready,
  input spte_pkg::res_t res
);
  import spte_pkg::*;

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // replies without a term are closing and empty
  a_reply: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.term_valid |->
      res.last && res.out_exponent == '0 && res.out_coefficient == '0)
    else $error("malformed reply word");

  // read-out terms carry no error
  a_term_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.term_valid |-> res.status == ST_OK)
    else $error("term word with status");

endmodule

bind sparse_polynomial_term_engine spte_chk u_chk (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import spte_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  sparse_polynomial_term_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the engine's polynomials
  logic signed [EXP_BITS-1:0]  poly_exp [MAX_TERMS];
  logic signed [COEF_BITS-1:0] poly_coef[MAX_TERMS];
  int                          poly_cnt;
  logic signed [EXP_BITS-1:0]  opnd_exp [MAX_TERMS];
  logic signed [COEF_BITS-1:0] opnd_coef[MAX_TERMS];
  int                          opnd_cnt;

  res_t expected_words[$];
  int   error_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  bit   timed_out;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic signed [COEF_BITS-1:0] sat_coef(input longint v,
                                                           inout logic [1:0] st);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COEF_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      if (st == ST_OK) st = ST_SAT;
      return hi[COEF_BITS-1:0];
    end
    if (v < lo) begin
      if (st == ST_OK) st = ST_SAT;
      return lo[COEF_BITS-1:0];
    end
    return v[COEF_BITS-1:0];
  endfunction

  // rounded half away from zero, then saturated
  function automatic logic signed [COEF_BITS-1:0] mul_coef(
      input logic signed [COEF_BITS-1:0] a, input logic signed [COEF_BITS-1:0] b,
      inout logic [1:0] st);
    bit          neg;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] p;
    logic [127:0] lim;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 128'(-longint'(a)) : 128'(longint'(a));
    mb  = (b < 0) ? 128'(-longint'(b)) : 128'(longint'(b));
    p   = ma * mb;
    if (FRAC_BITS > 0) p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? (128'd1 << (COEF_BITS - 1)) : ((128'd1 << (COEF_BITS - 1)) - 1);
    if (p > lim) begin
      if (st == ST_OK) st = ST_SAT;
      p = lim;
    end
    return neg ? -p[COEF_BITS-1:0] : p[COEF_BITS-1:0];
  endfunction

  task automatic sorted_insert(inout logic signed [EXP_BITS-1:0] ex[MAX_TERMS],
                               inout logic signed [COEF_BITS-1:0] co[MAX_TERMS],
                               inout int n, input logic signed [EXP_BITS-1:0] e,
                               input logic signed [COEF_BITS-1:0] c,
                               inout logic [1:0] st);
    int i;
    i = 0;
    while (i < n && ex[i] > e) i++;
    if (i < n && ex[i] == e) begin
      co[i] = sat_coef(longint'(co[i]) + longint'(c), st);
      return;
    end
    if (n >= MAX_TERMS) begin
      if (st == ST_OK) st = ST_FULL;
      return;
    end
    for (int k = n; k > i; k--) begin
      ex[k] = ex[k-1];
      co[k] = co[k-1];
    end
    ex[i] = e;
    co[i] = c;
    n++;
  endtask

  task automatic multiply_poly(inout logic [1:0] st);
    logic signed [EXP_BITS-1:0]  pe[MAX_TERMS];
    logic signed [COEF_BITS-1:0] pc[MAX_TERMS];
    int                          pn;
    longint                      e;
    longint                      emax;
    logic signed [COEF_BITS-1:0] c;
    pn   = 0;
    emax = (64'sd1 <<< (EXP_BITS - 1)) - 1;
    for (int k = 0; k < MAX_TERMS; k++) begin
      pe[k] = '0;
      pc[k] = '0;
    end
    if (opnd_cnt != 0) begin
      for (int i = 0; i < poly_cnt; i++) begin
        for (int j = 0; j < opnd_cnt; j++) begin
          e = longint'(poly_exp[i]) + longint'(opnd_exp[j]);
          if (e > emax || e < -emax - 1) begin
            if (st == ST_OK) st = ST_EOVF;
            continue;
          end
          c = mul_coef(poly_coef[i], opnd_coef[j], st);
          sorted_insert(pe, pc, pn, e[EXP_BITS-1:0], c, st);
        end
      end
    end
    poly_exp  = pe;
    poly_coef = pc;
    poly_cnt  = pn;
    opnd_cnt  = 0;
  endtask

  // expected words for one accepted command
  task automatic predict_words(input cmd_t w);
    res_t        r;
    logic [1:0]  st;
    st = ST_OK;
    r  = '0;
    if (w.op == OP_READ && poly_cnt > 0) begin
      for (int i = 0; i < poly_cnt; i++) begin
        r.out_exponent    = poly_exp[i];
        r.out_coefficient = poly_coef[i];
        r.term_valid      = 1'b1;
        r.last            = (i == poly_cnt - 1);
        r.status          = ST_OK;
        expected_words.push_back(r);
      end
      return;
    end
    case (w.op)
      OP_INSERT: sorted_insert(poly_exp, poly_coef, poly_cnt, w.term_exponent,
                               w.term_coefficient, st);
      OP_LOAD:   sorted_insert(opnd_exp, opnd_coef, opnd_cnt, w.term_exponent,
                               w.term_coefficient, st);
      OP_MUL:    multiply_poly(st);
      OP_CLEAR:  poly_cnt = 0;
      default: ;
    endcase
    r.last   = 1'b1;
    r.status = st;
    expected_words.push_back(r);
  endtask

  // send one command word; valid drops only while the sender idles
  task automatic send_word(input logic [2:0] op, input logic [EXP_BITS-1:0] e,
                           input logic [COEF_BITS-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{op: op, term_exponent: e, term_coefficient: c};
    do @(posedge clk); while (!cmd_ready);
    predict_words('{op: op, term_exponent: e, term_coefficient: c});
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else     res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_words.pop_front();
        if (res.out_exponent !== want.out_exponent)
          report_mismatch($sformatf("exponent %0d, want %0d", res.out_exponent,
                                    want.out_exponent));
        if (res.out_coefficient !== want.out_coefficient)
          report_mismatch($sformatf("coefficient %0h, want %0h", res.out_coefficient,
                                    want.out_coefficient));
        if (res.term_valid !== want.term_valid)
          report_mismatch($sformatf("term_valid %b, want %b", res.term_valid,
                                    want.term_valid));
        if (res.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", res.last, want.last));
        if (res.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  task automatic test_directed();
    // empty readout, empty multiply
    send_word(OP_READ, '0, '0);
    send_word(OP_MUL, '0, '0);
    // field extremes and accumulation onto an existing exponent
    send_word(OP_INSERT, 16'h7fff, 32'h7fffffff);
    send_word(OP_INSERT, 16'h8000, 32'h80000000);
    send_word(OP_INSERT, 16'h0000, 32'h00010000);
    send_word(OP_INSERT, 16'h7fff, 32'h00000001);   // saturates high
    send_word(OP_INSERT, 16'h8000, 32'hffffffff);   // saturates low
    send_word(OP_INSERT, 16'h0000, 32'hffff0000);   // sums to zero, kept
    send_word(OP_READ, '0, '0);
    // exponent overflow both ways, saturated products
    send_word(OP_LOAD, 16'h0001, 32'h7fffffff);
    send_word(OP_LOAD, 16'hffff, 32'h80000000);
    send_word(OP_MUL, '0, '0);
    send_word(OP_READ, '0, '0);
    // empty current times non-empty operand
    send_word(OP_CLEAR, '0, '0);
    send_word(OP_LOAD, 16'h0002, 32'h00018000);
    send_word(OP_MUL, '0, '0);
    // undefined codes
    send_word(3'd5, 16'h1234, 32'h5);
    send_word(3'd6, '0, '0);
    send_word(3'd7, 16'hffff, 32'hffffffff);
    // full table with one dropped term
    for (int i = 0; i <= MAX_TERMS; i++) send_word(OP_INSERT, 16'(i), 32'h10000);
    send_word(OP_READ, '0, '0);
    send_word(OP_CLEAR, '0, '0);
  endtask

  // mostly build / multiply / read sequences with random content
  task automatic test_random(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) < 8) begin
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          send_word(OP_INSERT, 16'($signed($urandom_range(40)) - 20),
                    ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(
                    32'h60000)) - 32'h30000));
        end
        sent += n;
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
          send_word(OP_LOAD, ($urandom_range(7) == 0) ? 16'($urandom) :
                    16'($signed($urandom_range(10)) - 5),
                    ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(
                    32'h40000)) - 32'h20000));
        end
        sent += n;
        if ($urandom_range(1)) begin
          send_word(OP_MUL, 16'($urandom), $urandom);
          sent++;
        end
        send_word(OP_READ, 16'($urandom), $urandom);
        sent++;
        if ($urandom_range(2) == 0) begin
          send_word(OP_CLEAR, '0, '0);
          sent++;
        end
      end else begin
        send_word(3'($urandom), 16'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    cmd           = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    timed_out     = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 68;
    poly_cnt      = 0;
    opnd_cnt      = 0;
    for (int k = 0; k < MAX_TERMS; k++) begin
      poly_exp[k] = '0; poly_coef[k] = '0; opnd_exp[k] = '0; opnd_coef[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(42);
    send_idle_pct = 68;
    recv_idle_pct = 28;
    test_random(42);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(42);
    cmd_valid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("tb_top: PASS");
    else                  $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("timeout: %0d words outstanding", expected_words.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
